FILE: rtl/core/tdsb_pkg.sv
// Package for the touch drag and swipe-back detector.
// Holds the event and result beat types, event and register codes and reset values.
// Depends on nothing; every other file of the block uses it.
package tdsb_pkg;

  // Width of one touch coordinate.
  localparam int unsigned COORD_BITS = 12;
  // A coordinate difference needs one more bit.
  localparam int unsigned DIFF_W     = COORD_BITS + 1;
  // dx*dx + dy*dy, at most 2^(2*COORD_BITS+1).
  localparam int unsigned SUM_W      = 2 * DIFF_W;
  // Signed width for the swipe compares: |dy| plus an 11-bit margin.
  localparam int unsigned CMP_W      = ((DIFF_W > 11) ? DIFF_W : 11) + 2;

  localparam int unsigned PADDR_W    = 4;
  localparam int unsigned PDATA_W    = 32;

  typedef enum logic [2:0] {
    MODE_PRESS    = 3'd0,
    MODE_PRESSING = 3'd1,
    MODE_RELEASE  = 3'd2,
    MODE_CANCEL   = 3'd3,
    MODE_GESTURE  = 3'd4,
    MODE_CLICK    = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    REG_DRAG_RADIUS    = 2'd0,
    REG_SWIPE_TRIGGER  = 2'd1,
    REG_SWIPE_MARGIN   = 2'd2,
    REG_BACK_COOLDOWN  = 2'd3
  } reg_e;

  localparam logic [7:0]  RST_DRAG_RADIUS   = 8'd12;
  localparam logic [15:0] RST_RADIUS_SQ     = 16'd144;
  localparam logic [10:0] RST_SWIPE_TRIGGER = 11'd36;
  localparam logic [10:0] RST_SWIPE_MARGIN  = 11'd12;
  localparam logic [15:0] RST_BACK_COOLDOWN = 16'd180;

  typedef struct packed {
    logic [2:0]                   mode;
    logic [1:0]                   device_id;
    logic                         is_pointer;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic [7:0]                   screen_id;
    logic                         swipe_enabled;
    logic                         gesture_right;
    logic                         back_accepted;
    logic [31:0]                  now_tick;
  } evt_t;

  typedef struct packed {
    logic back_triggered;
    logic suppress_click;
    logic release_was_drag;
  } res_t;

endpackage

FILE: rtl/core/tdsb_if.sv
// Valid/ready channel interfaces of the touch drag and swipe-back detector.
// One interface carries touch event beats, the other result beats.
// Depends on tdsb_pkg for the payload types.
interface tdsb_evt_if;
  logic            valid;
  logic            ready;
  tdsb_pkg::evt_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface tdsb_res_if;
  logic            valid;
  logic            ready;
  tdsb_pkg::res_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/touch_drag_and_swipe_back_detector.sv
// Touch drag and swipe-back detector, top level.
// Event beats arrive on evt_i, one result beat per event leaves on res_o,
// and four settings are written over an APB-style port.
//
// Usage:
// - evt_i carries one touch event per beat (press, move, release, cancel,
//   gesture, click). Every accepted event yields exactly one result beat on
//   res_o, in order.
// - The event is first captured in an input register. The compare logic
//   (drag radius check, swipe check, cooldown check) then runs on it and,
//   once the output register is free or its beat is being taken, the result
//   is written to the output register together with the updated tracking
//   state, from which it is offered on res_o.
// - Throughput is one event per cycle while res_o is not stalled. The tracking
//   state written by one event is visible to the event that follows it in
//   the next cycle, so back-to-back events see each other exactly in order.
// - When the receiver stalls, the output register holds its beat; the input
//   register still takes one more event, and evt_i.ready then drops until
//   the output beat is taken.
// - Reset (rst_ni low, asynchronous) empties both registers, clears all
//   touch and swipe tracking and restores the setting defaults (radius 12,
//   trigger 36, margin 12, cooldown 180 now_tick ticks).
// - Settings are to be written only while no event is in flight; the block does not enforce this.
module touch_drag_and_swipe_back_detector (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tdsb_evt_if.sink                      evt_i,
  tdsb_res_if.source                    res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tdsb_pkg::PADDR_W-1:0]  paddr,
  input  logic [tdsb_pkg::PDATA_W-1:0]  pwdata,
  output logic [tdsb_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int unsigned CW = tdsb_pkg::COORD_BITS;
  localparam int unsigned DW = tdsb_pkg::DIFF_W;
  localparam int unsigned SW = tdsb_pkg::SUM_W;
  localparam int unsigned KW = tdsb_pkg::CMP_W;

  // ------------------------------------------------------------------
  // Setting registers
  // ------------------------------------------------------------------
  logic [7:0]  radius_q;
  logic [15:0] radius_sq_q;   // Squared radius, computed when written.
  logic [10:0] trigger_q;
  logic [10:0] margin_q;
  logic [15:0] cooldown_q;

  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q    <= tdsb_pkg::RST_DRAG_RADIUS;
      radius_sq_q <= tdsb_pkg::RST_RADIUS_SQ;
      trigger_q   <= tdsb_pkg::RST_SWIPE_TRIGGER;
      margin_q    <= tdsb_pkg::RST_SWIPE_MARGIN;
      cooldown_q  <= tdsb_pkg::RST_BACK_COOLDOWN;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        tdsb_pkg::REG_DRAG_RADIUS: begin
          radius_q    <= pwdata[7:0];
          radius_sq_q <= 16'(pwdata[7:0] * pwdata[7:0]);
        end
        tdsb_pkg::REG_SWIPE_TRIGGER: trigger_q  <= pwdata[10:0];
        tdsb_pkg::REG_SWIPE_MARGIN:  margin_q   <= pwdata[10:0];
        tdsb_pkg::REG_BACK_COOLDOWN: cooldown_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      tdsb_pkg::REG_DRAG_RADIUS:   prdata = {24'd0, radius_q};
      tdsb_pkg::REG_SWIPE_TRIGGER: prdata = {21'd0, trigger_q};
      tdsb_pkg::REG_SWIPE_MARGIN:  prdata = {21'd0, margin_q};
      tdsb_pkg::REG_BACK_COOLDOWN: prdata = {16'd0, cooldown_q};
      default:                     prdata = '0;
    endcase
  end

  // ------------------------------------------------------------------
  // Input register and output register with their handshakes
  // ------------------------------------------------------------------
  logic            s1_valid_q;
  tdsb_pkg::evt_t  s1_q;
  logic            res_valid_q;
  tdsb_pkg::res_t  res_q;
  tdsb_pkg::res_t  res_d;
  logic            advance;

  // The event in the input register moves on when the output register is
  // empty or its beat is being taken in this cycle.
  assign advance     = s1_valid_q && (!res_valid_q || res_o.ready);
  assign evt_i.ready = !s1_valid_q || advance;
  assign res_o.valid   = res_valid_q;
  assign res_o.payload = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (evt_i.valid && evt_i.ready) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_i.valid && evt_i.ready) begin
      s1_q <= evt_i.payload;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  // ------------------------------------------------------------------
  // Touch and swipe tracking state
  // ------------------------------------------------------------------
  logic                  press_active_q, press_active_d;
  logic                  drag_active_q, drag_active_d;
  logic                  last_release_drag_q, last_release_drag_d;
  logic [1:0]            owner_device_q, owner_device_d;
  logic signed [CW-1:0]  press_start_x_q, press_start_x_d;
  logic signed [CW-1:0]  press_start_y_q, press_start_y_d;
  logic                  swipe_tracking_q, swipe_tracking_d;
  logic [7:0]            swipe_screen_q, swipe_screen_d;
  logic signed [CW-1:0]  swipe_start_x_q, swipe_start_x_d;
  logic signed [CW-1:0]  swipe_start_y_q, swipe_start_y_d;
  logic [31:0]           last_trigger_tick_q, last_trigger_tick_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_active_q      <= 1'b0;
      drag_active_q       <= 1'b0;
      last_release_drag_q <= 1'b0;
      owner_device_q      <= '0;
      press_start_x_q     <= '0;
      press_start_y_q     <= '0;
      swipe_tracking_q    <= 1'b0;
      swipe_screen_q      <= '0;
      swipe_start_x_q     <= '0;
      swipe_start_y_q     <= '0;
      last_trigger_tick_q <= '0;
    end else if (advance) begin
      press_active_q      <= press_active_d;
      drag_active_q       <= drag_active_d;
      last_release_drag_q <= last_release_drag_d;
      owner_device_q      <= owner_device_d;
      press_start_x_q     <= press_start_x_d;
      press_start_y_q     <= press_start_y_d;
      swipe_tracking_q    <= swipe_tracking_d;
      swipe_screen_q      <= swipe_screen_d;
      swipe_start_x_q     <= swipe_start_x_d;
      swipe_start_y_q     <= swipe_start_y_d;
      last_trigger_tick_q <= last_trigger_tick_d;
    end
  end

  // ------------------------------------------------------------------
  // Compare logic on the registered event
  // ------------------------------------------------------------------
  logic                  owner_match;
  logic signed [DW-1:0]  pdx, pdy;
  logic signed [SW-1:0]  pdx_sq, pdy_sq;
  logic [SW-1:0]         dist_sq;
  logic                  over_radius;

  // Drag test: squared distance from the press start against the squared
  // radius; only the owning device of an active press can drag.
  assign owner_match = press_active_q && (owner_device_q == s1_q.device_id);
  assign pdx     = DW'(s1_q.point_x) - DW'(press_start_x_q);
  assign pdy     = DW'(s1_q.point_y) - DW'(press_start_y_q);
  assign pdx_sq  = SW'(pdx) * SW'(pdx);
  assign pdy_sq  = SW'(pdy) * SW'(pdy);
  assign dist_sq = $unsigned(pdx_sq) + $unsigned(pdy_sq);
  assign over_radius = owner_match && (dist_sq >= SW'(radius_sq_q));

  logic signed [DW-1:0]  sdx, sdy;
  logic [DW-1:0]         sady;
  logic signed [KW-1:0]  sdx_c, sady_m, trig_c;
  logic                  swipe_hit;

  // Swipe test: rightward travel at least the trigger distance and
  // dominating the vertical travel by more than the margin.
  assign sdx    = DW'(s1_q.point_x) - DW'(swipe_start_x_q);
  assign sdy    = DW'(s1_q.point_y) - DW'(swipe_start_y_q);
  assign sady   = sdy[DW-1] ? $unsigned(-sdy) : $unsigned(sdy);
  assign sdx_c  = KW'(sdx);
  assign sady_m = $signed(KW'(sady) + KW'(margin_q));
  assign trig_c = $signed(KW'(trigger_q));
  assign swipe_hit = (sdx_c >= trig_c) && (sdx_c > sady_m);

  logic [31:0] since_last;
  logic        back_ok;

  // A back request is taken once the cooldown has run out (tick arithmetic
  // wraps) and the system accepts it.
  assign since_last = s1_q.now_tick - last_trigger_tick_q;
  assign back_ok    = (since_last >= 32'(cooldown_q)) && s1_q.back_accepted;

  always_comb begin
    logic want_back;

    want_back           = 1'b0;
    press_active_d      = press_active_q;
    drag_active_d       = drag_active_q;
    last_release_drag_d = last_release_drag_q;
    owner_device_d      = owner_device_q;
    press_start_x_d     = press_start_x_q;
    press_start_y_d     = press_start_y_q;
    swipe_tracking_d    = swipe_tracking_q;
    swipe_screen_d      = swipe_screen_q;
    swipe_start_x_d     = swipe_start_x_q;
    swipe_start_y_d     = swipe_start_y_q;
    last_trigger_tick_d = last_trigger_tick_q;
    res_d               = '0;

    if (s1_q.is_pointer) begin
      unique case (s1_q.mode)
        tdsb_pkg::MODE_PRESS: begin
          // A repeated press by the owner changes nothing; any other press
          // starts a new touch and takes over ownership.
          if (!owner_match) begin
            press_active_d      = 1'b1;
            drag_active_d       = 1'b0;
            last_release_drag_d = 1'b0;
            owner_device_d      = s1_q.device_id;
            press_start_x_d     = s1_q.point_x;
            press_start_y_d     = s1_q.point_y;
            if (s1_q.swipe_enabled) begin
              swipe_tracking_d = 1'b1;
              swipe_screen_d   = s1_q.screen_id;
              swipe_start_x_d  = s1_q.point_x;
              swipe_start_y_d  = s1_q.point_y;
            end else begin
              swipe_tracking_d = 1'b0;
              swipe_screen_d   = '0;
            end
          end
        end
        tdsb_pkg::MODE_PRESSING: begin
          if (over_radius) begin
            drag_active_d = 1'b1;
          end
        end
        tdsb_pkg::MODE_RELEASE, tdsb_pkg::MODE_CANCEL: begin
          if (owner_match) begin
            last_release_drag_d = drag_active_q || over_radius;
            press_active_d      = 1'b0;
            drag_active_d       = 1'b0;
            owner_device_d      = '0;
          end
          // Swipe tracking always ends here; only a release on the screen
          // where the swipe started may ask for back.
          swipe_tracking_d = 1'b0;
          swipe_screen_d   = '0;
          want_back = (s1_q.mode == tdsb_pkg::MODE_RELEASE) && swipe_tracking_q &&
                      (swipe_screen_q == s1_q.screen_id) && swipe_hit;
        end
        tdsb_pkg::MODE_GESTURE: begin
          drag_active_d = 1'b1;
          want_back     = s1_q.swipe_enabled && s1_q.gesture_right;
        end
        tdsb_pkg::MODE_CLICK: begin
          res_d.suppress_click = last_release_drag_q;
        end
        default: ;
      endcase

      if (want_back && back_ok) begin
        swipe_tracking_d    = 1'b0;
        swipe_screen_d      = '0;
        last_trigger_tick_d = s1_q.now_tick;
        res_d.back_triggered = 1'b1;
      end
      res_d.release_was_drag = last_release_drag_d;
    end
  end

endmodule
